>>> src/les_pkg.sv
package les_pkg;

  // Default grid limits
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int CNT_REG_W  = 11;
  localparam int SIDE_OUT_W = 11;
  localparam int POS_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Register reset values
  localparam logic [CHAR_W-1:0]    OBSTACLE_RST = 8'd111;
  localparam logic [CNT_REG_W-1:0] COUNT_RST    = 11'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE_CHAR = 2'd0,
    CFG_ROW_COUNT     = 2'd1,
    CFG_COL_COUNT     = 2'd2
  } cfg_reg_t;

  // Position flags of a cell travelling from the scan stage to the evaluate stage
  typedef struct packed {
    logic last;   // final cell of the grid
    logic row0;   // cell sits in the top row
    logic col0;   // cell sits in the left column
  } cell_tag_t;

endpackage

>>> src/les_ram.sv
module les_ram
  import les_pkg::*;
#(
  parameter int WIDTH = 11,
  parameter int DEPTH = DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/les_scan.sv
module les_scan
  import les_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic                        stall,
  input  logic [CHAR_W-1:0]           cell_char,
  input  logic [CHAR_W-1:0]           obstacle_char,
  input  logic [CNT_REG_W-1:0]        row_count,
  input  logic [CNT_REG_W-1:0]        col_count,
  output logic [$clog2(MAX_COLS)-1:0] rd_addr,
  output logic                        s1_valid,
  output logic                        s1_blocked,
  output cell_tag_t                   s1_tag,
  output logic [$clog2(MAX_ROWS)-1:0] s1_row,
  output logic [$clog2(MAX_COLS)-1:0] s1_col
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CNTC = (CW + 1 > CNT_REG_W) ? CW + 1 : CNT_REG_W;
  localparam int CNTR = (RW + 1 > CNT_REG_W) ? RW + 1 : CNT_REG_W;

  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CNTC-1:0] col_ext, cols_eff;
  logic [CNTR-1:0] row_ext, rows_eff;
  logic            col_end, row_end;
  logic            s1_valid_r, s1_blocked_r;
  cell_tag_t       s1_tag_r;
  logic [RW-1:0]   s1_row_r;
  logic [CW-1:0]   s1_col_r;

  // Clamp the counts: zero acts as one, anything beyond the limit as the limit
  always_comb begin
    col_ext  = CNTC'(col_count);
    row_ext  = CNTR'(row_count);
    cols_eff = (col_ext == '0) ? CNTC'(1) :
               (col_ext > CNTC'(MAX_COLS)) ? CNTC'(MAX_COLS) : col_ext;
    rows_eff = (row_ext == '0) ? CNTR'(1) :
               (row_ext > CNTR'(MAX_ROWS)) ? CNTR'(MAX_ROWS) : row_ext;
  end

  // Advance the raster position
  always_comb begin
    col_end = (CNTC'(col_r) + CNTC'(1)) >= cols_eff;
    row_end = (CNTR'(row_r) + CNTR'(1)) >= rows_eff;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (!stall) begin
        s1_valid_r <= in_fire;
      end
    end
  end

  // Capture the accepted word for the evaluate stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_blocked_r  <= (cell_char == obstacle_char);
      s1_tag_r.last <= col_end && row_end;
      s1_tag_r.row0 <= (row_r == '0);
      s1_tag_r.col0 <= (col_r == '0);
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
    end
  end

  assign rd_addr    = col_r;
  assign s1_valid   = s1_valid_r;
  assign s1_blocked = s1_blocked_r;
  assign s1_tag     = s1_tag_r;
  assign s1_row     = s1_row_r;
  assign s1_col     = s1_col_r;

endmodule

>>> src/les_eval.sv
module les_eval
  import les_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int SW       = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
  input  logic                        s1_valid,
  input  logic                        s1_blocked,
  input  cell_tag_t                   s1_tag,
  input  logic [$clog2(MAX_ROWS)-1:0] s1_row,
  input  logic [$clog2(MAX_COLS)-1:0] s1_col,
  input  logic [SW-1:0]               ram_rdata,
  output logic                        ram_we,
  output logic [SW-1:0]               ram_wdata,
  output logic                        stall,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [SIDE_OUT_W-1:0]       out_side,
  output logic [POS_OUT_W-1:0]        out_row,
  output logic [POS_OUT_W-1:0]        out_col
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic          s1_fire;
  logic          fwd_r;
  logic [SW-1:0] fwd_side_r;
  logic [SW-1:0] left_r, diag_r;
  logic [SW-1:0] up, left, diag, m_ul, m_all, side;
  logic [SW-1:0] best_side_r, cand_side;
  logic [RW-1:0] best_row_r, cand_row;
  logic [CW-1:0] best_col_r, cand_col;
  logic          better;
  logic          out_valid_r;
  logic [SIDE_OUT_W-1:0] out_side_r;
  logic [POS_OUT_W-1:0]  out_row_r, out_col_r;

  // Hold the last cell of a grid while a finished result still waits at the output
  assign stall   = s1_valid && s1_tag.last && out_valid_r && !out_ready;
  assign s1_fire = s1_valid && !stall;

  // Neighbor sides; take the entry written in the same cycle as the read if the read hit it
  always_comb begin
    up    = s1_tag.row0 ? '0 : (fwd_r ? fwd_side_r : ram_rdata);
    left  = s1_tag.col0 ? '0 : left_r;
    diag  = (s1_tag.row0 || s1_tag.col0) ? '0 : diag_r;
    m_ul  = (up < left) ? up : left;
    m_all = (m_ul < diag) ? m_ul : diag;
    side  = s1_blocked ? '0 : m_all + SW'(1);
  end

  // Keep the earliest square among equal sides
  always_comb begin
    better = side > best_side_r;
    if (better) begin
      cand_side = side;
      cand_row  = RW'((RW+1)'(s1_row) + (RW+1)'(1) - (RW+1)'(side));
      cand_col  = CW'((CW+1)'(s1_col) + (CW+1)'(1) - (CW+1)'(side));
    end else begin
      cand_side = best_side_r;
      cand_row  = best_row_r;
      cand_col  = best_col_r;
    end
  end

  assign ram_we    = s1_fire;
  assign ram_wdata = side;

  // Neighbor, best-square and bypass registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_side_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      fwd_r       <= 1'b0;
      fwd_side_r  <= '0;
    end else begin
      if (s1_fire) begin
        left_r <= side;
        diag_r <= up;
        if (s1_tag.last) begin
          best_side_r <= '0;
          best_row_r  <= '0;
          best_col_r  <= '0;
        end else begin
          best_side_r <= cand_side;
          best_row_r  <= cand_row;
          best_col_r  <= cand_col;
        end
      end
      if (in_fire) begin
        fwd_r      <= s1_fire && (rd_addr == s1_col);
        fwd_side_r <= side;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_tag.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_tag.last) begin
      out_side_r <= SIDE_OUT_W'(cand_side);
      out_row_r  <= POS_OUT_W'(cand_row);
      out_col_r  <= POS_OUT_W'(cand_col);
    end
  end

  assign out_valid = out_valid_r;
  assign out_side  = out_side_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;

endmodule

>>> src/largest_empty_square_finder.sv
// Channel | Dir | Ports                        | Word
// cfg     | in  | cfg_we, cfg_addr, cfg_wdata  | one register write, no handshake back
// in      | in  | in_tvalid/in_tready/in_tdata | one grid cell byte, row-major order
// out     | out | out_tvalid/out_tready/out_tdata | largest free square of one grid
//
// One cell is taken per cycle while in_tready is high; a result word is loaded into
// the output register when the last cell of a grid leaves the evaluate stage. The row
// buffer of sides is one single-port-read, single-port-write RAM, read when a cell is
// accepted and written when the cell leaves the evaluate stage, which a hold delays.
// in_tready drops only while the last cell of a grid waits on a full output register.
// Reset (rst_n low at a clock edge) restores the registers and restarts the grid;
// the row buffer is not cleared.
module largest_empty_square_finder
  import les_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CNT_REG_W-1:0]  cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] cell_char
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [10:0] square_side, [20:11] top_row,
                                            // [30:21] left_col, [31] zero
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int MINC = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int SW   = $clog2(MINC + 1);

  logic [CHAR_W-1:0]    obstacle_r;
  logic [CNT_REG_W-1:0] row_count_r, col_count_r;
  logic                 in_fire, stall;
  logic [CW-1:0]        rd_addr;
  logic                 s1_valid, s1_blocked;
  cell_tag_t            s1_tag;
  logic [RW-1:0]        s1_row;
  logic [CW-1:0]        s1_col;
  logic [SW-1:0]        ram_rdata, ram_wdata;
  logic                 ram_we;
  logic [SIDE_OUT_W-1:0] out_side;
  logic [POS_OUT_W-1:0]  out_row, out_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r  <= OBSTACLE_RST;
      row_count_r <= COUNT_RST;
      col_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_OBSTACLE_CHAR: obstacle_r  <= cfg_wdata[CHAR_W-1:0];
        CFG_ROW_COUNT:     row_count_r <= cfg_wdata;
        CFG_COL_COUNT:     col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !stall;
  assign in_fire   = in_tvalid && in_tready;

  les_scan #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .stall        (stall),
    .cell_char    (in_tdata[CHAR_W-1:0]),
    .obstacle_char(obstacle_r),
    .row_count    (row_count_r),
    .col_count    (col_count_r),
    .rd_addr      (rd_addr),
    .s1_valid     (s1_valid),
    .s1_blocked   (s1_blocked),
    .s1_tag       (s1_tag),
    .s1_row       (s1_row),
    .s1_col       (s1_col)
  );

  les_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_COLS)
  ) u_row_buf (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(s1_col),
    .wr_data(ram_wdata),
    .rd_en  (in_fire),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  les_eval #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .SW      (SW)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_blocked(s1_blocked),
    .s1_tag    (s1_tag),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_wdata (ram_wdata),
    .stall     (stall),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_side  (out_side),
    .out_row   (out_row),
    .out_col   (out_col)
  );

  // Pack the result word
  assign out_tdata = {1'b0, out_col, out_row, out_side};

endmodule

>>> src/les_chk.sv
module les_chk
  import les_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A waiting result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Input back-pressure only comes from a blocked result word
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

  // An empty answer sits at the origin
  a_zero_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:0] == 11'd0 |->
      out_tdata[20:11] == 10'd0 && out_tdata[30:21] == 10'd0)
    else $error("blocked grid reported a nonzero corner");

  // The square lies inside the grid limits
  a_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[20:11]) + 32'(out_tdata[10:0]) <= 32'(MAX_ROWS)) &&
                   (32'(out_tdata[30:21]) + 32'(out_tdata[10:0]) <= 32'(MAX_COLS)) &&
                   out_tdata[31] == 1'b0)
    else $error("reported square exceeds the grid");

endmodule

bind largest_empty_square_finder les_chk #(
  .MAX_COLS(MAX_COLS),
  .MAX_ROWS(MAX_ROWS)
) u_les_chk (.*);
